// ----- hw/rtl/tmfg_pkg.sv -----
// Shared types and constants for the torque mirror with following guard.
// Used by the channel interfaces, the step logic, the guard and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tmfg_pkg;

  localparam int unsigned QualifyMax    = 255;
  localparam int unsigned QualifyNeeded = 2;
  localparam int unsigned LimitReset    = 16384;
  localparam int unsigned RatioReset    = 1;

  localparam int unsigned RatioW  = 8;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 31;

  // Command codes carried by each item
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PAUSE   = 2'd1,
    CMD_RESUME  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DECIMATION_RATIO = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ERROR_LIMIT      = 1'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        leader_torque;
    logic [7:0]         leader_mode;
    logic               bus_busy;
    logic signed [31:0] commanded_position;
    logic signed [31:0] measured_position;
  } tick_t;

  typedef struct packed {
    logic               follower_write;
    logic [31:0]        follower_torque;
    logic               position_write;
    logic signed [31:0] position_value;
    logic               following_fault;
    logic               dropped_busy;
    logic [31:0]        processed_count;
    logic [31:0]        overrun_total;
  } result_t;

  typedef struct packed {
    logic [RatioW-1:0] decimation_ratio;
    logic [LimitW-1:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  qualify_count;
    logic [7:0]  decimation_count;
    logic [31:0] tick_total;
    logic [31:0] overrun_tally;
    logic        pause_flag;
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmfg_intf.sv -----
// Valid/ready channel interfaces for tick items and result items.
// Depends on tmfg_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface tmfg_tick_if import tmfg_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tmfg_result_if import tmfg_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/torque_mirror_with_following_guard_core.sv -----
// Top level of the torque mirror with following guard.
// Depends on tmfg_pkg, tmfg_intf (channels) and tmfg_step.
//
// Usage:
//   tick    : sink channel of tick items (command, torque, mode, bus flag,
//             commanded and measured position), valid/ready.
//   result  : source channel, exactly one result item per tick item.
//   cfg_*   : write port; cfg_index 0 is decimation_ratio, 1 is error_limit.
//             Write only while no item is in flight.
// Path: an accepted item sits in the input register, and its result is
//   loaded into the result register at the next edge when that register is
//   free.
// Throughput: one item per cycle while result.ready is high; the step logic
//   between the two registers is a few counters plus one 33-bit subtract and compare.
// Stall: while result.ready is low the result register holds, the input
//   register still fills, and tick.ready drops once both are full.
// Reset: rst (synchronous) empties both registers, clears all counters and
//   the pause flag, and loads decimation_ratio = 1, error_limit = 16384.
`timescale 1ns / 1ps
`default_nettype none

module torque_mirror_with_following_guard_core import tmfg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  tmfg_tick_if.sink                tick,
  tmfg_result_if.source            result,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  tick_t   item;
  logic    item_valid;
  result_t res;
  result_t res_q;
  logic    res_valid;
  logic    advance;

  // Move the held item into the result register when that register frees up
  assign advance      = item_valid && (!res_valid || result.ready);
  assign tick.ready   = !item_valid || advance;
  assign result.valid = res_valid;
  assign result.payload = res_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decimation_ratio <= RatioW'(RatioReset);
      cfg.error_limit      <= LimitW'(LimitReset);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DECIMATION_RATIO: cfg.decimation_ratio <= cfg_data[RatioW-1:0];
        REG_ERROR_LIMIT:      cfg.error_limit      <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (tick.ready) begin
      item_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      item <= tick.payload;
    end
  end

  tmfg_step u_step (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .res        (res)
  );

  // Counter state advances with each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmfg_guard.sv -----
// Following-error guard: full-width |commanded - measured| against the limit.
// Depends on tmfg_pkg for the limit width.
`timescale 1ns / 1ps
`default_nettype none

module tmfg_guard import tmfg_pkg::*; (
  input  wire logic signed [31:0] commanded,
  input  wire logic signed [31:0] measured,
  input  wire logic [LimitW-1:0]  limit,
  output logic                    fault
);

  logic signed [32:0] diff;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;

  // Subtract at 33 bits so the difference never wraps
  assign diff    = {commanded[31], commanded} - {measured[31], measured};
  assign lim_pos = $signed({2'b00, limit});
  assign lim_neg = -lim_pos;

  // Fault when the difference lies outside [-limit, +limit]
  assign fault = (diff > lim_pos) || (diff < lim_neg);

endmodule

`default_nettype wire

// ----- hw/rtl/tmfg_step.sv -----
// Per-item step logic: next counter state and the result for one tick item.
// Depends on tmfg_pkg and tmfg_guard.
`timescale 1ns / 1ps
`default_nettype none

module tmfg_step import tmfg_pkg::*; (
  input  wire tick_t  item,
  input  wire state_t state,
  input  wire cfg_t   cfg,
  output state_t      state_next,
  output result_t     res
);

  logic [RatioW-1:0] ratio_eff;
  logic [7:0]        decim_inc;
  logic [7:0]        qual_upd;
  logic [31:0]       tick_inc;
  logic              mode_ok;
  logic              decim_hit;
  logic              fault;
  cmd_t              cmd;

  assign cmd       = cmd_t'(item.command);
  assign ratio_eff = (cfg.decimation_ratio == '0) ? RatioW'(1) : cfg.decimation_ratio;
  assign decim_inc = state.decimation_count + 8'd1;
  assign decim_hit = decim_inc >= ratio_eff;
  assign tick_inc  = state.tick_total + 32'd1;
  assign mode_ok   = (item.leader_mode >= 8'd1) && (item.leader_mode <= 8'd3);

  // Saturate the qualify count while the mode stays qualified
  always_comb begin
    if (!mode_ok) begin
      qual_upd = 8'd0;
    end else if (state.qualify_count < 8'(QualifyMax)) begin
      qual_upd = state.qualify_count + 8'd1;
    end else begin
      qual_upd = state.qualify_count;
    end
  end

  tmfg_guard u_guard (
    .commanded (item.commanded_position),
    .measured  (item.measured_position),
    .limit     (cfg.error_limit),
    .fault     (fault)
  );

  // Apply the command, or drop / process the tick
  always_comb begin
    state_next = state;
    res        = '0;
    case (cmd)
      CMD_PAUSE: begin
        state_next.pause_flag = 1'b1;
      end
      CMD_RESUME: begin
        state_next.pause_flag = 1'b0;
      end
      CMD_RESTART: begin
        state_next = '0;
      end
      CMD_TICK: begin
        if (state.pause_flag) begin
          // drop without effect
        end else if (item.bus_busy) begin
          state_next.overrun_tally = state.overrun_tally + 32'd1;
          res.dropped_busy         = 1'b1;
        end else begin
          state_next.tick_total    = tick_inc;
          state_next.qualify_count = qual_upd;
          res.follower_write       = 1'b1;
          res.follower_torque      = (qual_upd < 8'(QualifyNeeded)) ? 32'd0 :
                                     item.leader_torque;
          if (decim_hit) begin
            state_next.decimation_count = 8'd0;
            res.position_write          = 1'b1;
            res.position_value          = item.commanded_position;
            res.following_fault         = fault;
          end else begin
            state_next.decimation_count = decim_inc;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    res.processed_count = state_next.tick_total;
    res.overrun_total   = state_next.overrun_tally;
  end

endmodule

`default_nettype wire
